[rtl/core/mps_pkg.sv]
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types, codes and constants of the maze path search core.
// ----------------------------------------------------------------------------
package mps_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // Width used for coordinate and size compares; holds any size up to 1024
    // plus one, and a coordinate that wrapped below zero reads as huge.
    localparam int CMP_W = 12;

    localparam int GRID_W = 7;
    localparam logic [GRID_W-1:0] GRID_RESET = 7'd63;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SEARCH = 2'd1,
        OP_READ   = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CELL_OPEN  = 2'd0,
        CELL_WALL  = 2'd1,
        CELL_ROUTE = 2'd2
    } t_cell;

    typedef enum logic [2:0] {
        DIR_WEST  = 3'd0,
        DIR_EAST  = 3'd1,
        DIR_NORTH = 3'd2,
        DIR_SOUTH = 3'd3,
        DIR_DONE  = 3'd4
    } t_dir;

    typedef enum logic {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_STEP,
        ST_NB_WAIT,
        ST_POP_WAIT
    } t_state;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] row;
        logic [5:0] col;
        logic       is_wall;
    } t_in_item;

    typedef struct packed {
        logic [1:0] cell_class;
        logic       goal_found;
        logic       error;
    } t_out_item;

    typedef struct packed {
        logic clr;        // clearing pass writes one cell
        logic user_wr;    // write the addressed cell
        logic user_rd;    // read the addressed cell
        logic start;      // begin a search at the start cell
        logic step;       // try the next neighbor of the top frame
        logic pop;        // reopen the top cell and drop the frame
        logic pop_load;   // take the frame below from the stack memory
        logic visit;      // enter the neighbor cell
        logic load_now;   // result with no class
        logic load_err;   // error bit for load_now
        logic load_rd;    // result carries the cell read
        logic load_done;  // result at the end of a search
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic in_grid;
        logic size_ok;
        logic found;
        logic sp_zero;
        logic dir_done;
        logic nb_in_grid;
        logic nb_open;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/core/mps_ctrl.sv]
// ----------------------------------------------------------------------------
// mps_ctrl
// Controller state machine: clearing pass, item dispatch and the search walk.
// ----------------------------------------------------------------------------
module mps_ctrl import mps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_op,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd,
    output logic       o_in_ready
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    case (i_op)
                        OP_WRITE: begin
                            o_cmd.user_wr  = i_sts.in_grid;
                            o_cmd.load_now = 1'b1;
                            o_cmd.load_err = !i_sts.in_grid;
                        end
                        OP_READ: begin
                            if (i_sts.in_grid) begin
                                o_cmd.user_rd = 1'b1;
                                n_state       = ST_READ;
                            end else begin
                                o_cmd.load_now = 1'b1;
                                o_cmd.load_err = 1'b1;
                            end
                        end
                        OP_SEARCH: begin
                            if (i_sts.size_ok) begin
                                o_cmd.start = 1'b1;
                                n_state     = ST_STEP;
                            end else begin
                                o_cmd.load_now = 1'b1;
                                o_cmd.load_err = 1'b1;
                            end
                        end
                        default: begin
                            o_cmd.load_now = 1'b1;
                            o_cmd.load_err = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                o_cmd.load_rd = 1'b1;
                n_state       = ST_IDLE;
            end
            ST_STEP: begin
                if (i_sts.found || i_sts.sp_zero) begin
                    o_cmd.load_done = 1'b1;
                    n_state         = ST_IDLE;
                end else if (i_sts.dir_done) begin
                    o_cmd.pop = 1'b1;
                    n_state   = ST_POP_WAIT;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_sts.nb_in_grid) begin
                        n_state = ST_NB_WAIT;
                    end
                end
            end
            ST_NB_WAIT: begin
                o_cmd.visit = i_sts.nb_open;
                n_state     = ST_STEP;
            end
            ST_POP_WAIT: begin
                o_cmd.pop_load = 1'b1;
                n_state        = ST_STEP;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/mps_datapath.sv]
// ----------------------------------------------------------------------------
// mps_datapath
// Cell store, search stack, top frame, size registers and result register.
// ----------------------------------------------------------------------------
module mps_datapath import mps_pkg::*; #(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  t_in_item          i_in_data,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [GRID_W-1:0] i_cfg_wdata,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output t_out_item         o_out_data
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam logic [CMP_W-1:0] ROWS_LIM = CMP_W'(MAX_ROWS);
    localparam logic [CMP_W-1:0] COLS_LIM = CMP_W'(MAX_COLS);
    localparam logic [CMP_W-1:0] ONE_X    = CMP_W'(1);
    localparam logic [CMP_W-1:0] TWO_X    = CMP_W'(2);
    localparam logic [CMP_W-1:0] THREE_X  = CMP_W'(3);

    typedef struct packed {
        logic [RW-1:0] r;
        logic [CW-1:0] c;
        t_dir          dir;
    } t_frame;

    t_cell  cell_mem [DEPTH];
    t_frame stk_mem  [DEPTH];

    t_cell             r_cell_rd;
    t_frame            r_stk_rd;
    logic [GRID_W-1:0] r_rows;
    logic [GRID_W-1:0] r_cols;
    logic              r_found;
    logic [AW:0]       r_sp;
    logic [AW-1:0]     r_clr;
    t_frame            r_top;
    logic [RW-1:0]     r_nb_r;
    logic [CW-1:0]     r_nb_c;
    t_out_item         r_out;
    logic              r_out_vld;

    logic [CMP_W-1:0] rows_x;
    logic [CMP_W-1:0] cols_x;
    logic [CMP_W-1:0] in_r_x;
    logic [CMP_W-1:0] in_c_x;
    logic [CMP_W-1:0] top_r_x;
    logic [CMP_W-1:0] top_c_x;
    logic [CMP_W-1:0] nb_r_x;
    logic [CMP_W-1:0] nb_c_x;
    logic [AW-1:0]    in_addr;
    logic             in_grid;
    logic             nb_in_grid;
    logic             nb_goal;
    logic             start_goal;
    logic             size_ok;
    logic             cell_we;
    logic [AW-1:0]    cell_wa;
    t_cell            cell_wd;
    logic [AW-1:0]    cell_ra;
    logic [AW:0]      sp_m1;
    logic [AW:0]      sp_m2;

    assign rows_x  = CMP_W'(r_rows);
    assign cols_x  = CMP_W'(r_cols);
    assign in_r_x  = CMP_W'(i_in_data.row);
    assign in_c_x  = CMP_W'(i_in_data.col);
    assign top_r_x = CMP_W'(r_top.r);
    assign top_c_x = CMP_W'(r_top.c);

    assign in_grid = (in_r_x < rows_x) && (in_r_x < ROWS_LIM)
                  && (in_c_x < cols_x) && (in_c_x < COLS_LIM);
    assign in_addr = {in_r_x[RW-1:0], in_c_x[CW-1:0]};

    assign size_ok = (rows_x >= THREE_X) && r_rows[0] && (rows_x <= ROWS_LIM)
                  && (cols_x >= THREE_X) && r_cols[0] && (cols_x <= COLS_LIM);

    // A step below row or column zero wraps to a huge value and so fails the
    // bounds compare, which makes outside cells act as walls.
    always_comb begin
        nb_r_x = top_r_x;
        nb_c_x = top_c_x;
        case (r_top.dir)
            DIR_WEST:  nb_c_x = top_c_x - ONE_X;
            DIR_EAST:  nb_c_x = top_c_x + ONE_X;
            DIR_NORTH: nb_r_x = top_r_x - ONE_X;
            DIR_SOUTH: nb_r_x = top_r_x + ONE_X;
            default:   ;
        endcase
    end

    assign nb_in_grid = (r_top.dir != DIR_DONE)
                     && (nb_r_x < rows_x) && (nb_r_x < ROWS_LIM)
                     && (nb_c_x < cols_x) && (nb_c_x < COLS_LIM);

    assign nb_goal    = (CMP_W'(r_nb_r) == rows_x - TWO_X)
                     && (CMP_W'(r_nb_c) == cols_x - TWO_X);
    assign start_goal = (ONE_X == rows_x - TWO_X) && (ONE_X == cols_x - TWO_X);

    always_comb begin
        cell_we = 1'b1;
        cell_wa = r_clr;
        cell_wd = CELL_WALL;
        if (i_cmd.clr) begin
            cell_wa = r_clr;
            cell_wd = CELL_WALL;
        end else if (i_cmd.user_wr) begin
            cell_wa = in_addr;
            cell_wd = i_in_data.is_wall ? CELL_WALL : CELL_OPEN;
        end else if (i_cmd.start) begin
            cell_wa = {RW'(1), CW'(1)};
            cell_wd = CELL_ROUTE;
        end else if (i_cmd.pop) begin
            cell_wa = {r_top.r, r_top.c};
            cell_wd = CELL_OPEN;
        end else if (i_cmd.visit) begin
            cell_wa = {r_nb_r, r_nb_c};
            cell_wd = CELL_ROUTE;
        end else begin
            cell_we = 1'b0;
        end
    end

    assign cell_ra = i_cmd.user_rd ? in_addr : {nb_r_x[RW-1:0], nb_c_x[CW-1:0]};

    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            cell_mem[cell_wa] <= cell_wd;
        end
        r_cell_rd <= cell_mem[cell_ra];
    end

    // The top frame lives in registers; the memory holds the frames below it.
    assign sp_m1 = r_sp - (AW+1)'(1);
    assign sp_m2 = r_sp - (AW+1)'(2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.visit) begin
            stk_mem[sp_m1[AW-1:0]] <= r_top;
        end
        r_stk_rd <= stk_mem[sp_m2[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_top <= '{r: RW'(1), c: CW'(1), dir: DIR_WEST};
        end else if (i_cmd.step) begin
            r_top.dir <= t_dir'(r_top.dir + 3'd1);
        end else if (i_cmd.pop_load) begin
            r_top <= r_stk_rd;
        end else if (i_cmd.visit) begin
            r_top <= '{r: r_nb_r, c: r_nb_c, dir: DIR_WEST};
        end
        if (i_cmd.step) begin
            r_nb_r <= nb_r_x[RW-1:0];
            r_nb_c <= nb_c_x[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= GRID_RESET;
            r_cols    <= GRID_RESET;
            r_found   <= 1'b0;
            r_sp      <= '0;
            r_clr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ROWS: r_rows <= i_cfg_wdata;
                    CFG_COLS: r_cols <= i_cfg_wdata;
                    default:  ;
                endcase
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.start) begin
                r_sp    <= (AW+1)'(1);
                r_found <= start_goal;
            end else if (i_cmd.pop) begin
                r_sp <= sp_m1;
            end else if (i_cmd.visit) begin
                r_sp <= r_sp + (AW+1)'(1);
                if (nb_goal) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.load_now || i_cmd.load_rd || i_cmd.load_done) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_now) begin
            r_out <= '{cell_class: 2'd0, goal_found: r_found, error: i_cmd.load_err};
        end else if (i_cmd.load_rd) begin
            r_out <= '{cell_class: r_cell_rd, goal_found: r_found, error: 1'b0};
        end else if (i_cmd.load_done) begin
            r_out <= '{cell_class: 2'd0, goal_found: r_found, error: 1'b0};
        end
    end

    assign o_sts.clear_last = &r_clr;
    assign o_sts.in_grid    = in_grid;
    assign o_sts.size_ok    = size_ok;
    assign o_sts.found      = r_found;
    assign o_sts.sp_zero    = (r_sp == '0);
    assign o_sts.dir_done   = (r_top.dir == DIR_DONE);
    assign o_sts.nb_in_grid = nb_in_grid;
    assign o_sts.nb_open    = (r_cell_rd == CELL_OPEN);
    assign o_sts.out_free   = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

[rtl/core/maze_path_search_core.sv]
// ----------------------------------------------------------------------------
// maze_path_search_core
// Maze grid store with a depth-first path search from (1,1) to the far corner.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the input channel (valid/ready) and every item gives exactly
// one result on the output channel (valid/ready). Op write sets a cell to wall
// or open, op read returns a cell's class, op search walks the maze.
// Grid size is set through the config port (index 0 rows, index 1 columns);
// the user must write it only while no item is in flight; nothing checks it.
// A write or an invalid item gives its result in the cycle after the
// transfer; a read goes through the cell store's registered read, then the
// output register. A search starts at (1,1), then tries each neighbor of the
// top frame: one outside the grid is skipped, one inside it is read first;
// backtracks reload the frame below; the single-port store sets that pace.
// After reset the cell store is swept to wall, one cell a cycle, over all
// MAX_ROWS_P2 * MAX_COLS_P2 cells (4096 at the defaults, each size rounded up
// to a power of two); no item is taken until the sweep ends.
// The result sits in an output register; while the receiver stalls it holds,
// and the next item is taken only in the cycle the result transfers.
// ----------------------------------------------------------------------------
module maze_path_search_core import mps_pkg::*; #(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [GRID_W-1:0] i_cfg_wdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    mps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.op),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    mps_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[rtl/core/mps_checker.sv]
// ----------------------------------------------------------------------------
// mps_checker
// Port-level checks of the maze path search core, bound to the top level.
// ----------------------------------------------------------------------------
module mps_checker import mps_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // A new item is never taken while a result waits on a stalled receiver.
    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while result is stalled");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Results with an error never carry a cell class.
    a_err_no_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error |-> o_out_data.cell_class == 2'd0)
        else $error("error result carries a class");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.cell_class != 2'd3)
        else $error("unknown cell class");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind maze_path_search_core mps_checker u_mps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
